/* rtl/pmh_pkg.sv */
// Shared types, constants and helper function of the path meta header step unit.
`timescale 1ns / 1ps
package pmh_pkg;

  localparam int unsigned FieldW   = 6;
  localparam int unsigned InfShift = 30;
  localparam int unsigned HopShift = 24;
  localparam int unsigned Seg0Shift = 12;
  localparam int unsigned Seg1Shift = 6;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_ORDER = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_AT_END    = 2'd3
  } status_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] word;
    logic [1:0]  inf;
    logic [5:0]  hop;
    logic [5:0]  seg0;
    logic [6:0]  s01;
    logic [7:0]  nhops;
    logic [1:0]  ninf;
    logic        bad;
  } dec_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] word;
    logic [1:0]  inf;
    logic [5:0]  hop;
    logic [7:0]  nhops;
    logic [1:0]  ninf;
    logic        bad;
    logic        xo;
    logic        axo;
    logic        at_end;
    logic [1:0]  nseg;
  } loc_t;

  typedef struct packed {
    logic        valid;
    status_t     status;
    logic [1:0]  curr_info;
    logic [5:0]  curr_hop;
    logic [1:0]  info_count;
    logic [7:0]  hop_count;
    logic        crossover;
    logic        after_crossover;
    logic [31:0] next_word;
  } res_t;

  // Segment index that holds hop hf.
  function automatic logic [1:0] seg_of_hop(input logic [6:0] hf, input logic [5:0] seg0,
                                            input logic [6:0] s01);
    logic [1:0] r;
    if (hf < {1'b0, seg0}) begin
      r = 2'd0;
    end else if (hf < s01) begin
      r = 2'd1;
    end else begin
      r = 2'd2;
    end
    return r;
  endfunction

endpackage

/* rtl/pmh_decode.sv */
// First stage: field unpacking, segment order check, info and hop counts.
`timescale 1ns / 1ps
module pmh_decode import pmh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_take,
  input  logic [31:0] in_meta_word,
  output dec_t        dec
);

  dec_t dec_r, dec_nxt;
  logic [5:0] seg0, seg1, seg2;

  always_comb begin
    seg0 = in_meta_word[Seg0Shift +: FieldW];
    seg1 = in_meta_word[Seg1Shift +: FieldW];
    seg2 = in_meta_word[FieldW-1:0];
    dec_nxt.valid = in_take;
    dec_nxt.word  = in_meta_word;
    dec_nxt.inf   = in_meta_word[InfShift +: 2];
    dec_nxt.hop   = in_meta_word[HopShift +: FieldW];
    dec_nxt.seg0  = seg0;
    dec_nxt.s01   = {1'b0, seg0} + {1'b0, seg1};
    dec_nxt.nhops = {2'b00, seg0} + {2'b00, seg1} + {2'b00, seg2};
    dec_nxt.bad   = ((seg1 == 6'd0) && (seg2 != 6'd0)) ||
                    ((seg0 == 6'd0) && ((seg1 | seg2) != 6'd0));
    if (seg2 != 6'd0) begin
      dec_nxt.ninf = 2'd3;
    end else if (seg1 != 6'd0) begin
      dec_nxt.ninf = 2'd2;
    end else if (seg0 != 6'd0) begin
      dec_nxt.ninf = 2'd1;
    end else begin
      dec_nxt.ninf = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r <= '0;
    end else begin
      dec_r <= dec_nxt;
    end
  end

  assign dec = dec_r;

endmodule

/* rtl/pmh_locate.sv */
// Second stage: segment lookup of neighboring hops, crossover flags and end check.
`timescale 1ns / 1ps
module pmh_locate import pmh_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  dec_t dec,
  output loc_t loc
);

  loc_t loc_r, loc_nxt;
  logic [6:0] hop_p1;
  logic [6:0] hop_m1;
  logic [1:0] pseg;

  always_comb begin
    hop_p1 = {1'b0, dec.hop} + 7'd1;
    hop_m1 = {1'b0, dec.hop} - 7'd1;
    pseg   = seg_of_hop(hop_m1, dec.seg0, dec.s01);
    loc_nxt.valid  = dec.valid;
    loc_nxt.word   = dec.word;
    loc_nxt.inf    = dec.inf;
    loc_nxt.hop    = dec.hop;
    loc_nxt.nhops  = dec.nhops;
    loc_nxt.ninf   = dec.ninf;
    loc_nxt.bad    = dec.bad;
    loc_nxt.nseg   = seg_of_hop(hop_p1, dec.seg0, dec.s01);
    loc_nxt.xo     = ({1'b0, hop_p1} < dec.nhops) && (dec.inf != loc_nxt.nseg);
    loc_nxt.axo    = (dec.inf != 2'd0) && (dec.hop != 6'd0) && ((dec.inf - 2'd1) == pseg);
    loc_nxt.at_end = (dec.nhops != 8'd0) && ({2'b00, dec.hop} >= (dec.nhops - 8'd1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loc_r <= '0;
    end else begin
      loc_r <= loc_nxt;
    end
  end

  assign loc = loc_r;

endmodule

/* rtl/pmh_pack.sv */
// Third stage: status priority and repacking of the advanced meta word.
`timescale 1ns / 1ps
module pmh_pack import pmh_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  loc_t loc,
  output res_t res
);

  res_t res_r, res_nxt;
  logic [7:0] last_hop;
  logic [5:0] hop_adv;

  always_comb begin
    last_hop = loc.nhops - 8'd1;
    hop_adv  = loc.hop + 6'd1;
    res_nxt.valid           = loc.valid;
    res_nxt.curr_info       = loc.inf;
    res_nxt.curr_hop        = loc.hop;
    res_nxt.info_count      = loc.ninf;
    res_nxt.hop_count       = loc.nhops;
    res_nxt.crossover       = loc.xo;
    res_nxt.after_crossover = loc.axo;
    if (loc.bad) begin
      res_nxt.status    = ST_BAD_ORDER;
      res_nxt.next_word = loc.word;
    end else if (loc.ninf == 2'd0) begin
      res_nxt.status    = ST_EMPTY;
      res_nxt.next_word = loc.word;
    end else if (loc.at_end) begin
      res_nxt.status    = ST_AT_END;
      res_nxt.next_word = {loc.inf, last_hop[5:0], 6'd0, loc.word[17:0]};
    end else begin
      res_nxt.status    = ST_OK;
      res_nxt.next_word = {loc.nseg, hop_adv, 6'd0, loc.word[17:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

/* rtl/path_meta_header_step_unit.sv */
// Top level of the path meta header step unit.
//
// The block takes one 32-bit path meta word per transfer on the input
// channel. A transfer happens at a rising edge where start is high and busy
// is low. Busy never rises, so a new word may be offered in every cycle.
//
// Each word gives exactly one result after the decode, hop lookup and repack
// registers. The result is shown on the out_ ports for one cycle while
// out_valid is high. Throughput is one word per cycle, set by the three
// register stages (decode, hop lookup, repack) that each take a new word
// every cycle.
// Synchronous reset clears the valid bits of all stages, so words in flight
// at reset are dropped and no result appears until new words arrive.
// The receiver has no way to hold a result, so nothing ever waits.
`timescale 1ns / 1ps
module path_meta_header_step_unit import pmh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_meta_word,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [1:0]  out_curr_info,
  output logic [5:0]  out_curr_hop,
  output logic [1:0]  out_info_count,
  output logic [7:0]  out_hop_count,
  output logic        out_crossover,
  output logic        out_after_crossover,
  output logic [31:0] out_next_word
);

  dec_t dec;
  loc_t loc;
  res_t res;

  assign busy = 1'b0;

  pmh_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_take     (start && !busy),
    .in_meta_word(in_meta_word),
    .dec         (dec)
  );

  pmh_locate u_locate (
    .clk  (clk),
    .rst_n(rst_n),
    .dec  (dec),
    .loc  (loc)
  );

  pmh_pack u_pack (
    .clk  (clk),
    .rst_n(rst_n),
    .loc  (loc),
    .res  (res)
  );

  assign out_valid           = res.valid;
  assign out_status          = res.status;
  assign out_curr_info       = res.curr_info;
  assign out_curr_hop        = res.curr_hop;
  assign out_info_count      = res.info_count;
  assign out_hop_count       = res.hop_count;
  assign out_crossover       = res.crossover;
  assign out_after_crossover = res.after_crossover;
  assign out_next_word       = res.next_word;

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("transfer did not produce a result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##3 !out_valid)
    else $error("result without a transfer");

  a_ok_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_OK)) |->
      (out_next_word[29:24] == (out_curr_hop + 6'd1)) && (out_next_word[23:18] == 6'd0))
    else $error("advanced hop index wrong");

  a_empty_no_hops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_EMPTY)) |->
      (out_hop_count == 8'd0) && (out_info_count == 2'd0))
    else $error("empty path with hops");
`endif

endmodule
